// ===== hdl/rmq_pkg.sv =====
// Package: widths, shared types and constants for the matrix-to-quaternion block.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	// axis selection codes
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2,
		AXIS_W = 2'd3
	} axis_t;
endpackage
`default_nettype wire

// ===== hdl/rmq_sqrt_cell.sv =====
// One cell of the pipelined square root: settles one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_cell import rmq_pkg::*; #(
	parameter int RW   = 40,
	parameter int SW   = 20,
	parameter int STEP = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vin,
	input  wire logic [RW-1:0] rad_in,
	input  wire logic [RW-1:0] rem_in,
	input  wire logic [SW-1:0] root_in,
	output logic               vout,
	output logic [RW-1:0]      rad_q,
	output logic [RW-1:0]      rem_q,
	output logic [SW-1:0]      root_q
);
	localparam int BITPOS = SW - 1 - STEP;
	logic [RW+1:0] rem2;
	logic [RW+1:0] trial;
	logic          fits;

	// shift in two radicand bits, try root*4+1
	always_comb begin
		rem2  = {rem_in, rad_in[2*BITPOS+1 -: 2]};
		trial = {{(RW+2-SW-2){1'b0}}, root_in, 2'b01};
		fits  = rem2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= rad_in;
		rem_q  <= fits ? RW'(rem2 - trial) : RW'(rem2);
		root_q <= {root_in[SW-2:0], fits};
	end
endmodule
`default_nettype wire

// ===== hdl/rmq_div_cell.sv =====
// One cell of the restoring divider: settles one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_cell import rmq_pkg::*; #(
	parameter int NW   = 48,
	parameter int DW   = 22,
	parameter int STEP = 0
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num_in,
	input  wire logic [DW-1:0] rem_in,
	input  wire logic [DW-1:0] den_in,
	input  wire logic [NW-1:0] quo_in,
	output logic [NW-1:0]      num_q,
	output logic [DW-1:0]      rem_q,
	output logic [DW-1:0]      den_q,
	output logic [NW-1:0]      quo_q
);
	localparam int BITPOS = NW - 1 - STEP;
	logic [DW:0] rem2;
	logic        fits;

	// bring down one numerator bit and compare
	always_comb begin
		rem2 = {rem_in, num_in[BITPOS]};
		fits = rem2 >= {1'b0, den_in};
	end

	always_ff @(posedge clk) begin
		num_q <= num_in;
		den_q <= den_in;
		rem_q <= fits ? DW'(rem2 - {1'b0, den_in}) : DW'(rem2);
		quo_q <= {quo_in[NW-2:0], fits};
	end
endmodule
`default_nettype wire

// ===== hdl/rmq_divider.sv =====
// Row of divider cells for one component, sign handling and saturation.
`timescale 1ns / 1ps
`default_nettype none
module rmq_divider import rmq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int SW         = 20
) (
	input  wire logic                  clk,
	input  wire logic signed [DATA_WIDTH+1:0] d,
	input  wire logic [SW-1:0]         s,
	output logic signed [DATA_WIDTH-1:0] q
);
	localparam int MW = DATA_WIDTH + 2;
	localparam int NW = MW + FRAC_BITS + 1;
	localparam int DW = SW + 1;
	localparam logic [NW-1:0] LIM = NW'(1) << (DATA_WIDTH - 1);

	logic [NW-1:0] num [NW+1];
	logic [DW-1:0] rem [NW+1];
	logic [DW-1:0] den [NW+1];
	logic [NW-1:0] quo [NW+1];
	logic          neg [NW+1];
	logic [MW-1:0] mag;

	// (|d| << F) + s over 2s rounds half away from zero
	always_comb begin
		mag    = d[MW-1] ? MW'(-d) : MW'(d);
		num[0] = NW'({mag, {FRAC_BITS{1'b0}}}) + NW'(s);
		rem[0] = '0;
		den[0] = {s, 1'b0};
		quo[0] = '0;
		neg[0] = d[MW-1];
	end

	for (genvar g = 0; g < NW; g++) begin : g_cell
		rmq_div_cell #(.NW(NW), .DW(DW), .STEP(g)) u_cell (
			.clk   (clk),
			.num_in(num[g]), .rem_in(rem[g]), .den_in(den[g]), .quo_in(quo[g]),
			.num_q (num[g+1]), .rem_q(rem[g+1]), .den_q(den[g+1]),
			.quo_q (quo[g+1])
		);
		always_ff @(posedge clk) neg[g+1] <= neg[g];
	end

	// saturate to the output range
	always_comb begin
		if (neg[NW]) begin
			q = (quo[NW] >= LIM) ? DATA_WIDTH'(-LIM) : DATA_WIDTH'(-quo[NW]);
		end else begin
			q = (quo[NW] >= LIM) ? DATA_WIDTH'(LIM - 1) : DATA_WIDTH'(quo[NW]);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/rotation_matrix_to_quaternion_top.sv =====
// Top level: matrix-to-quaternion conversion as a chain of root and divider cells.
`timescale 1ns / 1ps
`default_nettype none
// Takes one matrix per clock (busy stays low) and returns the quaternion through
// one input register, SW square-root cells (one root bit each,
// SW = (DATA_WIDTH+FRAC_BITS+3)/2), then DATA_WIDTH+FRAC_BITS+3 divider cells (one
// quotient bit each) and an output register. done pulses one cycle with qx..qw;
// the receiver cannot stall and need not, since results leave in input order.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire logic signed [DATA_WIDTH-1:0] e00, e01, e02,
	input  wire logic signed [DATA_WIDTH-1:0] e10, e11, e12,
	input  wire logic signed [DATA_WIDTH-1:0] e20, e21, e22,
	output logic      done,
	output logic signed [DATA_WIDTH-1:0] qx, qy, qz, qw
);
	localparam int MW = DATA_WIDTH + 2;
	localparam int RW0 = MW + FRAC_BITS;
	localparam int SW = (RW0 + 1) / 2;
	localparam int RW = 2 * SW;
	localparam int NW = MW + FRAC_BITS + 1;

	typedef logic signed [MW-1:0] wide_t;

	wide_t  rad_c, d0_c, d1_c, d2_c, dn_c;
	axis_t  lead_c;
	wide_t  d_s1 [4];
	axis_t  lead_s1;
	logic [RW-1:0] rad_s1;
	logic   v_s1;

	// branch pick, radicand and the three sums or differences
	always_comb begin
		wide_t a, b, c, tr, one;
		a   = MW'(e00);
		b   = MW'(e11);
		c   = MW'(e22);
		one = MW'(1) <<< FRAC_BITS;
		tr  = a + b + c;
		if (tr > 0) begin
			lead_c = AXIS_W;
			rad_c  = tr + one;
			d0_c = MW'(e21) - MW'(e12);
			d1_c = MW'(e02) - MW'(e20);
			d2_c = MW'(e10) - MW'(e01);
			dn_c = '0;
		end else if (c > ((b > a) ? b : a)) begin
			lead_c = AXIS_Z;
			rad_c  = c - a - b + one;
			d0_c = MW'(e20) + MW'(e02);
			d1_c = MW'(e21) + MW'(e12);
			d2_c = '0;
			dn_c = MW'(e10) - MW'(e01);
		end else if (b > a) begin
			lead_c = AXIS_Y;
			rad_c  = b - c - a + one;
			d0_c = MW'(e10) + MW'(e01);
			d1_c = '0;
			d2_c = MW'(e12) + MW'(e21);
			dn_c = MW'(e02) - MW'(e20);
		end else begin
			lead_c = AXIS_X;
			rad_c  = a - b - c + one;
			d0_c = '0;
			d1_c = MW'(e01) + MW'(e10);
			d2_c = MW'(e02) + MW'(e20);
			dn_c = MW'(e21) - MW'(e12);
		end
		if (rad_c < 1) rad_c = MW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		rad_s1  <= RW'({rad_c[MW-2:0], {FRAC_BITS{1'b0}}});
		lead_s1 <= lead_c;
		d_s1[0] <= d0_c;
		d_s1[1] <= d1_c;
		d_s1[2] <= d2_c;
		d_s1[3] <= dn_c;
	end

	// square-root cell chain
	logic [RW-1:0] srad [SW+1];
	logic [RW-1:0] srem [SW+1];
	logic [SW-1:0] sroot [SW+1];
	logic          sv [SW+1];
	wide_t         sd [SW+1][4];
	axis_t         slead [SW+1];

	assign srad[0]  = rad_s1;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign sv[0]    = v_s1;
	assign slead[0] = lead_s1;
	for (genvar k = 0; k < 4; k++) begin : g_d0
		assign sd[0][k] = d_s1[k];
	end

	for (genvar g = 0; g < SW; g++) begin : g_sq
		rmq_sqrt_cell #(.RW(RW), .SW(SW), .STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .vin(sv[g]),
			.rad_in(srad[g]), .rem_in(srem[g]), .root_in(sroot[g]),
			.vout(sv[g+1]), .rad_q(srad[g+1]), .rem_q(srem[g+1]),
			.root_q(sroot[g+1])
		);
		always_ff @(posedge clk) begin
			slead[g+1] <= slead[g];
			for (int k = 0; k < 4; k++) sd[g+1][k] <= sd[g][k];
		end
	end

	// divider rows, one per component
	logic signed [DATA_WIDTH-1:0] dq [4];
	for (genvar k = 0; k < 4; k++) begin : g_div
		rmq_divider #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
			.clk(clk), .d(sd[SW][k]), .s(sroot[SW]), .q(dq[k])
		);
	end

	// leading component and branch tag delayed alongside the dividers
	logic [SW-1:0] half_q [NW+1];
	axis_t         dlead [NW+1];
	logic          dv [NW+1];
	assign half_q[0] = sroot[SW] >> 1;
	assign dlead[0]  = slead[SW];
	assign dv[0]     = sv[SW];
	for (genvar g = 0; g < NW; g++) begin : g_dly
		always_ff @(posedge clk) begin
			half_q[g+1] <= half_q[g];
			dlead[g+1]  <= dlead[g];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[g+1] <= 1'b0;
			end else begin
				dv[g+1] <= dv[g];
			end
		end
	end

	logic signed [DATA_WIDTH-1:0] lead_val;
	logic [SW-1:0] lim;
	always_comb begin
		lim = SW'(1) << (DATA_WIDTH - 1);
		lead_val = (half_q[NW] >= lim) ? DATA_WIDTH'(lim - 1) : DATA_WIDTH'(half_q[NW]);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv[NW];
		end
	end

	always_ff @(posedge clk) begin
		qx <= (dlead[NW] == AXIS_X) ? lead_val : dq[0];
		qy <= (dlead[NW] == AXIS_Y) ? lead_val : dq[1];
		qz <= (dlead[NW] == AXIS_Z) ? lead_val : dq[2];
		qw <= (dlead[NW] == AXIS_W) ? lead_val : dq[3];
	end

	assign busy = 1'b0;
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the matrix-to-quaternion block: directed and random matrices, checked per item.
`timescale 1ns / 1ps
module tb_top;
	import rmq_pkg::*;

	localparam int DW = 16;
	localparam int FB = 14;
	// input register + root cells + divider cells + output register
	localparam int LATENCY = 2 + (DW + FB + 3) / 2 + (DW + FB + 3);
	localparam int CYCLE_LIMIT = 200000;

	typedef logic signed [DW-1:0] elem_t;
	typedef struct packed {
		elem_t x, y, z, w;
	} quat_t;

	logic clk, arst_n, start, busy, done;
	elem_t e00, e01, e02, e10, e11, e12, e20, e21, e22;
	elem_t qx, qy, qz, qw;

	quat_t expected_quats[$];
	int mismatches, quats_seen, matrices_sent, cycles;
	int diag_branch_cnt, trace_branch_cnt;

	rotation_matrix_to_quaternion_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.e00(e00), .e01(e01), .e02(e02), .e10(e10), .e11(e11), .e12(e12),
		.e20(e20), .e21(e21), .e22(e22),
		.done(done), .qx(qx), .qy(qy), .qz(qz), .qw(qw)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturate a signed value to the element range
	function automatic elem_t clamp_elem(input longint v);
		longint lim;
		lim = longint'(1) << (DW - 1);
		if (v >= lim) return elem_t'(lim - 1);
		if (v < -lim) return elem_t'(-lim);
		return elem_t'(v);
	endfunction

	function automatic longint int_sqrt(input longint v);
		longint lo, hi, mid;
		lo = 0;
		hi = 64'd3037000499;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// d * 2^FB / (2s), rounded half away from zero
	function automatic elem_t half_over_root(input longint d, input longint s);
		longint mag, q;
		mag = (d < 0) ? -d : d;
		q = ((mag << FB) + s) / (2 * s);
		return clamp_elem((d < 0) ? -q : q);
	endfunction

	function automatic longint root_of(input longint r);
		if (r < 1) r = 1;
		return int_sqrt(r << FB);
	endfunction

	function automatic quat_t quat_from_matrix(input elem_t mat [3][3]);
		longint m [3][3];
		longint tr, s;
		int i, j, k;
		elem_t q [3];
		elem_t w;
		quat_t res;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				m[r][c] = mat[r][c];
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			trace_branch_cnt++;
			s = root_of(tr + (longint'(1) << FB));
			w = clamp_elem(s >> 1);
			q[0] = half_over_root(m[2][1] - m[1][2], s);
			q[1] = half_over_root(m[0][2] - m[2][0], s);
			q[2] = half_over_root(m[1][0] - m[0][1], s);
		end else begin
			diag_branch_cnt++;
			i = AXIS_X;
			if (m[1][1] > m[0][0]) i = AXIS_Y;
			if (m[2][2] > m[i][i]) i = AXIS_Z;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			s = root_of(m[i][i] - m[j][j] - m[k][k] + (longint'(1) << FB));
			q[i] = clamp_elem(s >> 1);
			w = half_over_root(m[k][j] - m[j][k], s);
			q[j] = half_over_root(m[j][i] + m[i][j], s);
			q[k] = half_over_root(m[k][i] + m[i][k], s);
		end
		res.x = q[0];
		res.y = q[1];
		res.z = q[2];
		res.w = w;
		return res;
	endfunction

	// sender burst control
	int burst_left;

	task automatic send_matrix(input elem_t mat [3][3]);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		start <= 1'b1;
		{e00, e01, e02} <= {mat[0][0], mat[0][1], mat[0][2]};
		{e10, e11, e12} <= {mat[1][0], mat[1][1], mat[1][2]};
		{e20, e21, e22} <= {mat[2][0], mat[2][1], mat[2][2]};
		do @(posedge clk); while (busy);
		expected_quats.push_back(quat_from_matrix(mat));
		matrices_sent++;
		@(negedge clk);
	endtask

	task automatic finish_sending();
		start <= 1'b0;
	endtask

	function automatic elem_t rand_elem();
		return elem_t'($urandom);
	endfunction

	function automatic elem_t near(input int v, input int spread);
		return clamp_elem(v + $signed($urandom_range(2 * spread)) - spread);
	endfunction

	// result checker
	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n && done) begin
			quats_seen++;
			if (expected_quats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: quaternion with none expected");
			end else begin
				exp_q = expected_quats.pop_front();
				if (exp_q !== {qx, qy, qz, qw}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: quat %0d exp x=%0d y=%0d z=%0d w=%0d got %0d %0d %0d %0d",
							quats_seen, exp_q.x, exp_q.y, exp_q.z, exp_q.w, qx, qy, qz, qw);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// identity, extremes, sign-flip rotations, ties
	task automatic test_directed();
		elem_t m [3][3];
		int one;
		one = 1 << FB;
		m = '{'{one, 0, 0}, '{0, one, 0}, '{0, 0, one}};
		send_matrix(m);
		m = '{'{one, 0, 0}, '{0, -one, 0}, '{0, 0, -one}};
		send_matrix(m);
		m = '{'{-one, 0, 0}, '{0, one, 0}, '{0, 0, -one}};
		send_matrix(m);
		m = '{'{-one, 0, 0}, '{0, -one, 0}, '{0, 0, one}};
		send_matrix(m);
		// trace exactly zero
		m = '{'{0, -one, 0}, '{one, 0, 0}, '{0, 0, 0}};
		send_matrix(m);
		// diagonal ties
		m = '{'{0, 100, 0}, '{0, 0, 0}, '{0, 0, 0}};
		send_matrix(m);
		m = '{'{-one, 5, 7}, '{3, -one, 9}, '{11, 13, -one}};
		send_matrix(m);
		// extreme diagonal entries, in the trace branch and in the diagonal branch
		m = '{'{-32768, 0, 0}, '{0, 32767, 0}, '{0, 0, 32767}};
		send_matrix(m);
		m = '{'{-32768, 32767, -32768}, '{32767, -32768, 32767},
			'{-32768, 32767, -32768}};
		send_matrix(m);
		// all maxima, all minima, saturating outputs
		m = '{'{32767, 32767, 32767}, '{32767, 32767, 32767}, '{32767, 32767, 32767}};
		send_matrix(m);
		m = '{'{-32768, -32768, -32768}, '{-32768, -32768, -32768},
			'{-32768, -32768, -32768}};
		send_matrix(m);
		m = '{'{1, 32767, -32768}, '{-32768, -1, 32767}, '{32767, -32768, 0}};
		send_matrix(m);
		m = '{'{-one + 1, -32768, 32767}, '{32767, -one, -32768}, '{-32768, 32767, -one}};
		send_matrix(m);
		m = '{'{1, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};
		send_matrix(m);
	endtask

	// mostly near-rotation matrices, with fully random ones mixed in
	task automatic test_random(input int count);
		elem_t m [3][3];
		int one, sel;
		one = 1 << FB;
		repeat (count) begin
			sel = $urandom_range(9);
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					m[r][c] = (sel < 3) ? rand_elem() : near(0, one);
			if (sel >= 3 && sel < 8) begin
				// all three diagonals near +one or -one, each sign picked at random
				for (int d = 0; d < 3; d++)
					m[d][d] = near(($urandom_range(1)) ? one : -one, one / 2);
			end
			send_matrix(m);
		end
	endtask

	initial begin
		int drain;
		arst_n = 1'b0;
		start = 1'b0;
		{e00, e01, e02, e10, e11, e12, e20, e21, e22} = '0;
		mismatches = 0;
		quats_seen = 0;
		matrices_sent = 0;
		cycles = 0;
		burst_left = 0;
		diag_branch_cnt = 0;
		trace_branch_cnt = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(840);
		finish_sending();
		drain = 0;
		while (expected_quats.size() != 0 && drain < 20 * LATENCY) begin
			@(posedge clk);
			drain++;
		end
		repeat (LATENCY) @(posedge clk);
		if (expected_quats.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d quaternions never arrived", expected_quats.size());
		end
		$display("Sent %0d matrices (%0d trace branch, %0d diagonal branch), checked %0d results",
			matrices_sent, trace_branch_cnt, diag_branch_cnt, quats_seen);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== rotation_matrix_to_quaternion_top.f =====
hdl/rmq_pkg.sv
hdl/rmq_sqrt_cell.sv
hdl/rmq_div_cell.sv
hdl/rmq_divider.sv
hdl/rotation_matrix_to_quaternion_top.sv
verif/tb_top.sv
